// ===== hdl/lsct_pkg.sv =====
// Shared types, codes and quarter-wave tables for the sine/cosine/tangent interpolator.
package lsct_pkg;

  typedef enum logic [1:0] {
    OP_SIN = 2'd0,
    OP_COS = 2'd1,
    OP_TAN = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_SIN,
    KIND_TAN,
    KIND_NONE
  } kind_t;

  localparam int PointW = 28;
  localparam logic [14:0] QuarterTurn = 15'd8192;
  localparam logic signed [PointW-1:0] PoleValue = 28'sd26214400;
  localparam logic [7:0] RomLast = 8'd128;

  localparam logic [15:0] SINE_ROM [0:128] = '{
    16'd0, 16'd402, 16'd804, 16'd1206, 16'd1607, 16'd2009, 16'd2410, 16'd2811, 16'd3211,
    16'd3611, 16'd4011, 16'd4409, 16'd4808, 16'd5205, 16'd5602, 16'd5997, 16'd6392, 16'd6786,
    16'd7179, 16'd7571, 16'd7961, 16'd8351, 16'd8739, 16'd9126, 16'd9512, 16'd9896, 16'd10278,
    16'd10659, 16'd11039, 16'd11416, 16'd11793, 16'd12167, 16'd12539, 16'd12910, 16'd13278,
    16'd13645, 16'd14010, 16'd14372, 16'd14732, 16'd15090, 16'd15446, 16'd15800, 16'd16151,
    16'd16499, 16'd16846, 16'd17189, 16'd17530, 16'd17869, 16'd18204, 16'd18537, 16'd18868,
    16'd19195, 16'd19519, 16'd19841, 16'd20159, 16'd20475, 16'd20787, 16'd21097, 16'd21403,
    16'd21706, 16'd22005, 16'd22301, 16'd22594, 16'd22884, 16'd23170, 16'd23453, 16'd23732,
    16'd24007, 16'd24279, 16'd24547, 16'd24812, 16'd25073, 16'd25330, 16'd25583, 16'd25832,
    16'd26077, 16'd26319, 16'd26557, 16'd26790, 16'd27020, 16'd27245, 16'd27466, 16'd27684,
    16'd27897, 16'd28106, 16'd28310, 16'd28511, 16'd28707, 16'd28898, 16'd29086, 16'd29269,
    16'd29447, 16'd29621, 16'd29791, 16'd29956, 16'd30117, 16'd30273, 16'd30425, 16'd30572,
    16'd30714, 16'd30852, 16'd30985, 16'd31114, 16'd31237, 16'd31357, 16'd31471, 16'd31581,
    16'd31685, 16'd31785, 16'd31881, 16'd31971, 16'd32057, 16'd32138, 16'd32214, 16'd32285,
    16'd32351, 16'd32413, 16'd32469, 16'd32521, 16'd32568, 16'd32610, 16'd32647, 16'd32679,
    16'd32706, 16'd32728, 16'd32745, 16'd32758, 16'd32765, 16'd32768
  };

  localparam logic [24:0] TAN_ROM [0:128] = '{
    25'd0, 25'd804, 25'd1608, 25'd2413, 25'd3219, 25'd4026, 25'd4834, 25'd5643, 25'd6454,
    25'd7267, 25'd8083, 25'd8900, 25'd9721, 25'd10544, 25'd11371, 25'd12201, 25'd13035,
    25'd13874, 25'd14716, 25'd15563, 25'd16415, 25'd17273, 25'd18136, 25'd19005, 25'd19880,
    25'd20761, 25'd21650, 25'd22545, 25'd23449, 25'd24360, 25'd25280, 25'd26208, 25'd27145,
    25'd28092, 25'd29050, 25'd30017, 25'd30996, 25'd31986, 25'd32988, 25'd34002, 25'd35029,
    25'd36070, 25'd37125, 25'd38195, 25'd39280, 25'd40382, 25'd41500, 25'd42635, 25'd43789,
    25'd44962, 25'd46155, 25'd47369, 25'd48604, 25'd49862, 25'd51144, 25'd52451, 25'd53784,
    25'd55143, 25'd56531, 25'd57949, 25'd59398, 25'd60879, 25'd62395, 25'd63946, 25'd65535,
    25'd67164, 25'd68834, 25'd70548, 25'd72307, 25'd74115, 25'd75974, 25'd77886, 25'd79855,
    25'd81884, 25'd83976, 25'd86135, 25'd88365, 25'd90669, 25'd93053, 25'd95522, 25'd98081,
    25'd100736, 25'd103492, 25'd106358, 25'd109340, 25'd112446, 25'd115687, 25'd119071,
    25'd122609, 25'd126313, 25'd130197, 25'd134275, 25'd138564, 25'd143081, 25'd147846,
    25'd152883, 25'd158217, 25'd163877, 25'd169895, 25'd176309, 25'd183160, 25'd190499,
    25'd198380, 25'd206869, 25'd216043, 25'd225990, 25'd236816, 25'd248647, 25'd261634,
    25'd275959, 25'd291845, 25'd309567, 25'd329471, 25'd351993, 25'd377693, 25'd407305,
    25'd441807, 25'd482534, 25'd531351, 25'd590957, 25'd665398, 25'd761030, 25'd888449,
    25'd1066729, 25'd1334015, 25'd1779313, 25'd2669640, 25'd5340085, 25'd26214400
  };

  // Table reads; indexes past the last entry read as zero.
  function automatic logic [15:0] sine_rom(input logic [7:0] idx);
    logic [15:0] r;
    r = 16'd0;
    if (idx <= RomLast) begin
      r = SINE_ROM[idx];
    end
    return r;
  endfunction

  function automatic logic [24:0] tan_rom(input logic [7:0] idx);
    logic [24:0] r;
    r = 25'd0;
    if (idx <= RomLast) begin
      r = TAN_ROM[idx];
    end
    return r;
  endfunction

endpackage

// ===== hdl/lsct_point.sv =====
// Folds a table point index onto the quarter-wave sine or half-turn tangent table.
module lsct_point (
  input  logic                                 is_tan,
  input  logic                                 lower,
  input  logic [8:0]                           point,
  output logic signed [lsct_pkg::PointW-1:0]   pt_value
);

  logic [6:0] v;
  logic [7:0] v_fwd;
  logic [7:0] v_rev;
  logic signed [lsct_pkg::PointW-1:0] sin_fwd;
  logic signed [lsct_pkg::PointW-1:0] sin_rev;
  logic signed [lsct_pkg::PointW-1:0] tan_fwd;
  logic signed [lsct_pkg::PointW-1:0] tan_rev;

  assign v     = point[6:0];
  assign v_fwd = {1'b0, v};
  assign v_rev = lsct_pkg::RomLast - v_fwd;

  assign sin_fwd = $signed({12'd0, lsct_pkg::sine_rom(v_fwd)});
  assign sin_rev = $signed({12'd0, lsct_pkg::sine_rom(v_rev)});
  assign tan_fwd = $signed({3'd0, lsct_pkg::tan_rom(v_fwd)});
  assign tan_rev = $signed({3'd0, lsct_pkg::tan_rom(v_rev)});

  always_comb begin
    pt_value = '0;
    if (is_tan) begin
      // The pole point reads as the negative pole when it is the lower point.
      if (point[7:0] == lsct_pkg::RomLast) begin
        pt_value = lower ? -lsct_pkg::PoleValue : lsct_pkg::PoleValue;
      end else if (!point[7]) begin
        pt_value = tan_fwd;
      end else begin
        pt_value = -tan_rev;
      end
    end else begin
      case (point[8:7])
        2'd0: pt_value = sin_fwd;
        2'd1: pt_value = sin_rev;
        2'd2: pt_value = -sin_fwd;
        2'd3: pt_value = -sin_rev;
        default: pt_value = '0;
      endcase
    end
  end

endmodule

// ===== hdl/lut_sin_cos_tan_interpolator.sv =====
// Top level of the table-driven sine, cosine and tangent interpolator.
//
//   channel | signals                       | payload
//   --------+-------------------------------+------------------------------------
//   request | req_valid, req_ready          | op (2b), angle (16b signed)
//   result  | rsp_valid, rsp_ready          | value (22b signed, 10.12 fixed)
//
// The pipeline has four register stages. One item can enter every cycle while
// the result side is not stalling.
// The rate is set by the per-stage valid and ready chain; the subtraction of the
// two points and the multiply by the weight share the third stage.
// Reset clears only the stage valid bits; payload registers are not reset.
// When the result side stalls, each stage holds its item until the stage after
// it frees up, so bubbles close up and nothing is dropped or repeated.
module lut_sin_cos_tan_interpolator (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [1:0]         op,
  input  logic signed [15:0] angle,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic signed [21:0] value
);

  localparam int PW = lsct_pkg::PointW;

  // Stage valid bits and the ready chain that lets bubbles collapse.
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !v4 || rsp_ready;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign req_ready = rdy1;
  assign rsp_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= req_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
    end
  end

  // Stage 1: reduce the angle to one turn, add the quarter turn for cosine, and
  // split it into a table point and a 6-bit weight.
  logic [14:0]         turn_next;
  lsct_pkg::kind_t     kind_next;
  logic [8:0]          idx1;
  logic [5:0]          w1;
  lsct_pkg::kind_t     kind1;

  assign turn_next = angle[14:0] +
                     ((op == lsct_pkg::OP_COS) ? lsct_pkg::QuarterTurn : 15'd0);

  always_comb begin
    case (op)
      lsct_pkg::OP_SIN: kind_next = lsct_pkg::KIND_SIN;
      lsct_pkg::OP_COS: kind_next = lsct_pkg::KIND_SIN;
      lsct_pkg::OP_TAN: kind_next = lsct_pkg::KIND_TAN;
      default:          kind_next = lsct_pkg::KIND_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      idx1  <= turn_next[14:6];
      w1    <= turn_next[5:0];
      kind1 <= kind_next;
    end
  end

  // Stage 2: look up the two neighboring table points with quadrant folding.
  logic [8:0]            idx_up;
  logic                  is_tan1;
  logic signed [PW-1:0]  lo_pt;
  logic signed [PW-1:0]  hi_pt;
  logic signed [PW-1:0]  prev2;
  logic signed [PW-1:0]  next2;
  logic [5:0]            w2;
  lsct_pkg::kind_t       kind2;

  assign idx_up  = idx1 + 9'd1;
  assign is_tan1 = (kind1 == lsct_pkg::KIND_TAN);

  lsct_point u_lo (
    .is_tan   (is_tan1),
    .lower    (1'b1),
    .point    (idx1),
    .pt_value (lo_pt)
  );

  lsct_point u_hi (
    .is_tan   (is_tan1),
    .lower    (1'b0),
    .point    (idx_up),
    .pt_value (hi_pt)
  );

  always_ff @(posedge clk) begin
    if (rdy2) begin
      // An unused op code forces both points to zero, giving a zero result.
      prev2 <= (kind1 == lsct_pkg::KIND_NONE) ? '0 : lo_pt;
      next2 <= (kind1 == lsct_pkg::KIND_NONE) ? '0 : hi_pt;
      w2    <= w1;
      kind2 <= kind1;
    end
  end

  // Stage 3: scale the point difference by the weight.
  logic signed [PW-1:0] diff;
  logic signed [6:0]    w_s;
  logic signed [PW+6:0] prod_next;
  logic signed [PW+6:0] prod3;
  logic signed [PW-1:0] prev3;
  lsct_pkg::kind_t      kind3;

  assign diff      = next2 - prev2;
  assign w_s       = $signed({1'b0, w2});
  assign prod_next = diff * w_s;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      prod3 <= prod_next;
      prev3 <= prev2;
      kind3 <= kind2;
    end
  end

  // Stage 4: arithmetic shift of the product, add the lower point, and scale
  // to 10.12 (three bits down for sine and cosine, four for tangent).
  logic signed [PW:0]   scaled;
  logic signed [PW:0]   sum;
  logic signed [21:0]   value_next;

  assign scaled = $signed(prod3[PW+6:6]);
  assign sum    = $signed({prev3[PW-1], prev3}) + scaled;

  always_comb begin
    if (kind3 == lsct_pkg::KIND_TAN) begin
      value_next = $signed(sum[25:4]);
    end else begin
      value_next = $signed(sum[24:3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      value <= value_next;
    end
  end

endmodule
